>>> sv/assert_macros.svh
// Assertion macros shared by the dwstat RTL files.
// Plain text only, no dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define DW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define DW_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> sv/dwstat_pkg.sv
// Types, constants and codes shared by the window dinucleotide statistics block.
// No dependencies.
package dwstat_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int ACC_BITS_DEF   = 48;

    localparam int N_DINUC = 16;          // dinucleotide kinds
    localparam int IDX_W   = 4;           // dinucleotide index width
    localparam int SPAN_W  = 6;           // window span register width
    localparam int CNT_W   = 7;           // window count, modulo 128 (count never above 64)
    localparam int SQ_W    = 2 * CNT_W;   // squared window count
    localparam int OUT_W   = 48;          // result field width

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_DINUC - 1);

    typedef enum logic [1:0] {
        CMD_BASE = 2'd0,
        CMD_EOS  = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic {
        KIND_WIN  = 1'b0,   // complete window to accumulate
        KIND_READ = 1'b1    // read out and clear
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_stage;

    // one modular count per dinucleotide
    typedef logic [N_DINUC-1:0][CNT_W-1:0] t_cntvec;

endpackage

>>> sv/dwstat_front.sv
// Input register, sequence tracking and running dinucleotide counts with
// their history memory. Depends on dwstat_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dwstat_front import dwstat_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_in_valid,
    input  logic [1:0]        i_cmd,
    input  logic [1:0]        i_base,
    input  logic              i_cfg_we,
    input  logic [SPAN_W-1:0] i_cfg_wdata,
    output t_stage            o_stage,
    output t_cntvec           o_now,
    output t_cntvec           o_old
);

    localparam int HIST_AW   = $clog2(MAX_WINDOW);
    localparam int DEPTH     = 1 << HIST_AW;
    localparam int PW        = HIST_AW + CNT_W;
    localparam int NSEQ_MAX  = MAX_WINDOW + 2;
    localparam int NSEQ_W    = $clog2(MAX_WINDOW + 3);
    localparam int SPAN_MAX  = MAX_WINDOW - 1;

    logic               r_in_valid;
    logic [1:0]         r_in_cmd;
    logic [1:0]         r_in_base;
    logic [SPAN_W-1:0]  r_span;
    logic [NSEQ_W-1:0]  r_nseq;
    logic [1:0]         r_prev;
    logic [HIST_AW-1:0] r_wp;
    t_cntvec            r_cum;
    t_stage             r_stage;
    t_cntvec            r_now;
    t_cntvec            r_old;
    t_cntvec            mem [DEPTH];

    logic [SPAN_W-1:0]  span_eff;
    logic [CNT_W-1:0]   back_len;
    logic [PW-1:0]      rd_full;
    logic [HIST_AW-1:0] rd_addr;
    logic [IDX_W-1:0]   pair;
    logic               pair_ok;
    logic               complete;
    logic               fire_base;
    logic [NSEQ_W-1:0]  n_nseq;
    t_cntvec            n_cum;

    // Each memory entry holds the running counts after one base; the window
    // counts are the difference between now and span+1 bases back.
    always_comb begin
        span_eff  = (int'(r_span) > SPAN_MAX) ? SPAN_W'(SPAN_MAX) : r_span;
        back_len  = CNT_W'(span_eff) + CNT_W'(1);
        rd_full   = PW'(r_wp) - PW'(back_len);
        rd_addr   = rd_full[HIST_AW-1:0];
        pair      = {r_prev, r_in_base};
        pair_ok   = (r_nseq != '0);
        n_nseq    = (int'(r_nseq) < NSEQ_MAX) ? r_nseq + NSEQ_W'(1) : r_nseq;
        complete  = int'(n_nseq) >= int'(span_eff) + 2;
        fire_base = i_adv && r_in_valid && (r_in_cmd == CMD_BASE);
        for (int d = 0; d < N_DINUC; d++) begin
            n_cum[d] = r_cum[d] + CNT_W'(pair_ok && (pair == IDX_W'(d)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_span     <= '0;
            r_nseq     <= '0;
            r_wp       <= '0;
            r_cum      <= '0;
            r_stage    <= '{valid: 1'b0, kind: KIND_WIN};
        end else begin
            if (i_cfg_we) begin
                r_span <= i_cfg_wdata;
            end
            if (i_adv) begin
                r_in_valid <= i_in_valid;
                r_stage    <= '{valid: 1'b0, kind: KIND_WIN};
                if (r_in_valid) begin
                    case (r_in_cmd)
                        CMD_BASE: begin
                            r_nseq <= n_nseq;
                            r_cum  <= n_cum;
                            r_wp   <= r_wp + HIST_AW'(1);
                            if (complete) begin
                                r_stage <= '{valid: 1'b1, kind: KIND_WIN};
                            end
                        end
                        CMD_EOS: begin
                            r_nseq <= '0;
                        end
                        CMD_READ: begin
                            r_stage <= '{valid: 1'b1, kind: KIND_READ};
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_in_valid) begin
            r_in_cmd  <= i_cmd;
            r_in_base <= i_base;
        end
        if (fire_base) begin
            r_prev       <= r_in_base;
            mem[r_wp]    <= n_cum;
            r_now        <= n_cum;
            r_old        <= mem[rd_addr];
        end
    end

    assign o_stage = r_stage;
    assign o_now   = r_now;
    assign o_old   = r_old;

    `DW_NEVER(a_nseq_bound, i_clk, i_rst_n, (int'(r_nseq) > NSEQ_MAX), "base count overrun")

endmodule

>>> sv/dwstat_acc.sv
// Window counts and squares, saturating accumulators, readout drain and the
// result register. Depends on dwstat_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dwstat_acc import dwstat_pkg::*; #(
    parameter int ACC_BITS = ACC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stage           i_stage,
    input  t_cntvec          i_now,
    input  t_cntvec          i_old,
    input  logic             i_out_ready,
    output logic             o_adv,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_idx,
    output logic [OUT_W-1:0] o_count_sum,
    output logic [OUT_W-1:0] o_square_sum,
    output logic [OUT_W-1:0] o_window_total,
    output logic             o_last
);

    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

    t_stage                   r_stage;
    t_cntvec                  r_cnt;
    logic [SQ_W-1:0]          r_sq    [N_DINUC];
    logic [ACC_BITS-1:0]      r_acc_c [N_DINUC];
    logic [ACC_BITS-1:0]      r_acc_s [N_DINUC];
    logic [ACC_BITS-1:0]      r_wcnt;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_o_valid;
    logic [IDX_W-1:0]         r_o_idx;
    logic [OUT_W-1:0]         r_o_cs;
    logic [OUT_W-1:0]         r_o_ss;
    logic [OUT_W-1:0]         r_o_wt;
    logic                     r_o_last;

    t_cntvec                  n_cnt;
    logic [SQ_W-1:0]          n_sq    [N_DINUC];
    logic [ACC_BITS-1:0]      n_acc_c [N_DINUC];
    logic [ACC_BITS-1:0]      n_acc_s [N_DINUC];
    logic [ACC_BITS-1:0]      n_wcnt;
    logic [ACC_BITS:0]        sum_c   [N_DINUC];
    logic [ACC_BITS:0]        sum_s   [N_DINUC];
    logic [ACC_BITS:0]        sum_w;
    logic                     is_read;
    logic                     is_win;
    logic                     out_free;
    logic                     load;
    logic                     done;

    // Count stage: modular difference of running counts, then its square.
    always_comb begin
        for (int d = 0; d < N_DINUC; d++) begin
            n_cnt[d] = i_now[d] - i_old[d];
            n_sq[d]  = SQ_W'(n_cnt[d]) * SQ_W'(n_cnt[d]);
        end
    end

    // Accumulate stage: add with a carry bit, clamp on carry.
    always_comb begin
        for (int d = 0; d < N_DINUC; d++) begin
            sum_c[d]   = {1'b0, r_acc_c[d]} + (ACC_BITS+1)'(r_cnt[d]);
            sum_s[d]   = {1'b0, r_acc_s[d]} + (ACC_BITS+1)'(r_sq[d]);
            n_acc_c[d] = sum_c[d][ACC_BITS] ? ACC_MAX : sum_c[d][ACC_BITS-1:0];
            n_acc_s[d] = sum_s[d][ACC_BITS] ? ACC_MAX : sum_s[d][ACC_BITS-1:0];
        end
        sum_w  = {1'b0, r_wcnt} + (ACC_BITS+1)'(1);
        n_wcnt = sum_w[ACC_BITS] ? ACC_MAX : sum_w[ACC_BITS-1:0];
    end

    // A readout holds the stage until the last of its sixteen results is loaded for output.
    always_comb begin
        is_read  = r_stage.valid && (r_stage.kind == KIND_READ);
        is_win   = r_stage.valid && (r_stage.kind == KIND_WIN);
        out_free = !r_o_valid || i_out_ready;
        load     = is_read && out_free;
        done     = load && (r_idx == LAST_IDX);
        o_adv    = !is_read || done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= '{valid: 1'b0, kind: KIND_WIN};
            r_idx     <= '0;
            r_o_valid <= 1'b0;
            r_wcnt    <= '0;
            for (int d = 0; d < N_DINUC; d++) begin
                r_acc_c[d] <= '0;
                r_acc_s[d] <= '0;
            end
        end else begin
            if (o_adv) begin
                r_stage <= i_stage;
            end
            if (load) begin
                r_idx <= done ? '0 : r_idx + IDX_W'(1);
            end
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (is_win) begin
                r_wcnt <= n_wcnt;
                for (int d = 0; d < N_DINUC; d++) begin
                    r_acc_c[d] <= n_acc_c[d];
                    r_acc_s[d] <= n_acc_s[d];
                end
            end else if (done) begin
                r_wcnt <= '0;
                for (int d = 0; d < N_DINUC; d++) begin
                    r_acc_c[d] <= '0;
                    r_acc_s[d] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_cnt <= n_cnt;
            for (int d = 0; d < N_DINUC; d++) begin
                r_sq[d] <= n_sq[d];
            end
        end
        if (load) begin
            r_o_idx  <= r_idx;
            r_o_cs   <= OUT_W'(r_acc_c[r_idx]);
            r_o_ss   <= OUT_W'(r_acc_s[r_idx]);
            r_o_wt   <= OUT_W'(r_wcnt);
            r_o_last <= (r_idx == LAST_IDX);
        end
    end

    assign o_valid        = r_o_valid;
    assign o_idx          = r_o_idx;
    assign o_count_sum    = r_o_cs;
    assign o_square_sum   = r_o_ss;
    assign o_window_total = r_o_wt;
    assign o_last         = r_o_last;

    `DW_NEVER(a_idx_drain, i_clk, i_rst_n, ((r_idx != '0) && !is_read), "stray drain index")
    `DW_ASSERT(a_clr_drain, i_clk, i_rst_n, (done |=> (r_wcnt == '0)), "sums kept")

endmodule

>>> sv/window_dinucleotide_stats_unit.sv
// Top level of the window dinucleotide statistics block: stream ports,
// span register port, front end and accumulator stage. Depends on dwstat_pkg.
//
//  channel  | direction | accepted when                    | carries
//  ---------+-----------+----------------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid & s_axis_tready    | cmd (tuser), base (tdata)
//  m_axis   | out       | m_axis_tvalid & m_axis_tready    | index, sums, windows, last
//  cfg      | in        | i_cfg_we                         | window span
//
// Base and end-of-sequence items go in at one per cycle unless a readout drains; a
// complete window passes the input register, front end count registers and count
// stage to the accumulators. A readout occupies the accumulator stage until its
// sixteen results are loaded for output, with input held off until the last one.
// The history memory needs no clearing pass: an unwritten entry is never
// read for a complete window, so reset only clears the control and sums.
// Synchronous active-low reset on i_rst_n.
module window_dinucleotide_stats_unit import dwstat_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int ACC_BITS   = ACC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [1:0] base, [7:2] zero
    input  logic [1:0]           s_axis_tuser,   // cmd
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [3*OUT_W-1:0]   m_axis_tdata,   // count_sum, square_sum, window_total
    output logic [IDX_W-1:0]     m_axis_tuser,   // dinuc_index
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [SPAN_W-1:0]    i_cfg_wdata
);

    logic             adv;
    t_stage           stage;
    t_cntvec          cnt_now;
    t_cntvec          cnt_old;
    logic [OUT_W-1:0] count_sum;
    logic [OUT_W-1:0] square_sum;
    logic [OUT_W-1:0] window_total;

    // Whole pipeline advances together; stall only while a readout drains.
    assign s_axis_tready = adv;

    dwstat_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_in_valid  (s_axis_tvalid),
        .i_cmd       (s_axis_tuser),
        .i_base      (s_axis_tdata[1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stage     (stage),
        .o_now       (cnt_now),
        .o_old       (cnt_old)
    );

    dwstat_acc #(
        .ACC_BITS (ACC_BITS)
    ) u_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stage        (stage),
        .i_now          (cnt_now),
        .i_old          (cnt_old),
        .i_out_ready    (m_axis_tready),
        .o_adv          (adv),
        .o_valid        (m_axis_tvalid),
        .o_idx          (m_axis_tuser),
        .o_count_sum    (count_sum),
        .o_square_sum   (square_sum),
        .o_window_total (window_total),
        .o_last         (m_axis_tlast)
    );

    // Pack results, first field lowest.
    assign m_axis_tdata = {window_total, square_sum, count_sum};

endmodule
